// ----- rtl/core/lrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_pkg
// Types and constants shared by the front end, the work queue and the
// interpolation back end of the 48 kHz resampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Output rate, lowest stepping rate and per-input result cap
  localparam logic [16:0] OUT_RATE = 17'd48000;
  localparam logic [15:0] MIN_RATE = 16'd8000;
  localparam logic [2:0]  MAX_OUT  = 3'd6;

  // fraction = (phase*32768 + 24000) / 48000 = (phase*2048 + 1500) / 3000
  // Division by 3000 is a multiply by ceil(2^39/3000) and a shift by 39,
  // exact for numerators below 2^27.
  localparam logic [26:0] FRAC_BIAS = 27'd1500;
  localparam logic [27:0] RECIP_M   = 28'd183251938;
  localparam int          RECIP_SH  = 39;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    K_PASS,
    K_FIRST,
    K_INTERP
  } kind_t;

  // One unit of work: base frame (or previous frame) plus channel deltas
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] base_l;
    logic signed [15:0] base_r;
    logic signed [16:0] dlt_l;
    logic signed [16:0] dlt_r;
  } desc_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FRAC,
    BK_MUL,
    BK_RND,
    BK_OUT
  } bk_state_t;

  // Round half away from zero, then divide by 32768 truncating toward zero
  function automatic logic signed [18:0] rnd_q15(input logic signed [33:0] p);
    logic signed [34:0] b;
    logic signed [34:0] t;
    b = p[33] ? ($signed({p[33], p}) - 35'sd16384) : ($signed({p[33], p}) + 35'sd16384);
    t = b[34] ? (b + 35'sd32767) : b;
    return t[33:15];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lrs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_front
// Accepts source words, classifies them (passthrough, first frame, or
// interpolation), tracks the previous frame and queues the work descriptor.
// ----------------------------------------------------------------------------
module lrs_front import lrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_clear,
  input  wire logic               pass_mode,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_left_in,
  input  wire logic signed [15:0] in_right_in,
  output      logic               push_valid,
  input  wire logic               push_ready,
  output      desc_t              push_desc
);

  logic               have_prev_r;
  logic               have_prev_nxt;
  logic signed [15:0] prev_l_r;
  logic signed [15:0] prev_l_nxt;
  logic signed [15:0] prev_r_r;
  logic signed [15:0] prev_r_nxt;
  logic               accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  // Classify the incoming word
  always_comb begin
    push_desc.kind   = K_PASS;
    push_desc.base_l = in_left_in;
    push_desc.base_r = in_right_in;
    push_desc.dlt_l  = '0;
    push_desc.dlt_r  = '0;
    have_prev_nxt    = have_prev_r;
    prev_l_nxt       = prev_l_r;
    prev_r_nxt       = prev_r_r;
    if (pass_mode) begin
      push_desc.kind = K_PASS;
    end else if (!have_prev_r) begin
      push_desc.kind = K_FIRST;
      have_prev_nxt  = 1'b1;
      prev_l_nxt     = in_left_in;
      prev_r_nxt     = in_right_in;
    end else begin
      push_desc.kind   = K_INTERP;
      push_desc.base_l = prev_l_r;
      push_desc.base_r = prev_r_r;
      push_desc.dlt_l  = $signed({in_left_in[15], in_left_in}) -
                         $signed({prev_l_r[15], prev_l_r});
      push_desc.dlt_r  = $signed({in_right_in[15], in_right_in}) -
                         $signed({prev_r_r[15], prev_r_r});
      prev_l_nxt       = in_left_in;
      prev_r_nxt       = in_right_in;
    end
  end

  // Previous frame state; config write restarts the stream
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      have_prev_r <= 1'b0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
    end else if (accept) begin
      have_prev_r <= have_prev_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_r_r    <= prev_r_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lrs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_queue
// Small FIFO of work descriptors between front end and back end.
// ----------------------------------------------------------------------------
module lrs_queue import lrs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output      logic  push_ready,
  input  wire desc_t push_desc,
  output      logic  pop_valid,
  input  wire logic  pop_ready,
  output      desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  desc_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_desc   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lrs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_back
// Takes work descriptors and produces the 48 kHz output words: passthrough
// and first frames go out directly, interpolation walks the phase
// accumulator one output instant at a time through the fraction and product multiplies.
// ----------------------------------------------------------------------------
module lrs_back import lrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_clear,
  input  wire logic [15:0]        rate_eff,
  input  wire logic               pop_valid,
  output      logic               pop_ready,
  input  wire desc_t              pop_desc,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_left_out,
  output      logic signed [15:0] out_right_out,
  output      logic               out_last_of_run
);

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  kind_t              kind_r;
  logic signed [15:0] base_l_r;
  logic signed [15:0] base_r_r;
  logic signed [16:0] dlt_l_r;
  logic signed [16:0] dlt_r_r;
  logic [15:0]        phase_r;
  logic [16:0]        sum_r;
  logic [2:0]         cnt_r;
  logic [54:0]        mul_r;
  logic signed [33:0] prod_l_r;
  logic signed [33:0] prod_r_r;
  logic signed [15:0] out_l_r;
  logic signed [15:0] out_r_r;
  logic               last_r;

  logic [26:0]        num;
  logic signed [16:0] frac_s;
  logic [16:0]        sum_c;
  logic signed [18:0] q_l;
  logic signed [18:0] q_r;
  logic signed [18:0] y_l;
  logic signed [18:0] y_r;
  logic               phase_in_win;

  // Datapath helpers
  assign phase_in_win = ({1'b0, phase_r} <= OUT_RATE);
  assign num          = {phase_r, 11'b0} + FRAC_BIAS;
  assign frac_s       = {1'b0, mul_r[RECIP_SH+15:RECIP_SH]};
  assign sum_c        = {1'b0, phase_r} + {1'b0, rate_eff};
  assign q_l          = rnd_q15(prod_l_r);
  assign q_r          = rnd_q15(prod_r_r);
  assign y_l          = $signed({{3{base_l_r[15]}}, base_l_r}) + q_l;
  assign y_r          = $signed({{3{base_r_r[15]}}, base_r_r}) + q_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          if (pop_desc.kind == K_INTERP) begin
            state_nxt = phase_in_win ? BK_FRAC : BK_IDLE;
          end else begin
            state_nxt = BK_OUT;
          end
        end
      end
      BK_FRAC: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_RND;
      BK_RND:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_ready) begin
          state_nxt = last_r ? BK_IDLE : BK_FRAC;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready       = (state_r == BK_IDLE);
    out_valid       = (state_r == BK_OUT);
    out_left_out    = out_l_r;
    out_right_out   = out_r_r;
    out_last_of_run = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Phase accumulator and run counter
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (pop_valid) begin
            cnt_r <= '0;
            if (pop_desc.kind == K_FIRST) begin
              phase_r <= rate_eff;
            end else if (pop_desc.kind == K_INTERP && !phase_in_win) begin
              phase_r <= phase_r - OUT_RATE[15:0];
            end
          end
        end
        BK_OUT: begin
          if (out_ready) begin
            if (!last_r) begin
              phase_r <= sum_r[15:0];
              cnt_r   <= cnt_r + 1'b1;
            end else if (kind_r == K_INTERP) begin
              phase_r <= (sum_r > OUT_RATE) ? 16'(sum_r - OUT_RATE) : sum_r[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          kind_r   <= pop_desc.kind;
          base_l_r <= pop_desc.base_l;
          base_r_r <= pop_desc.base_r;
          dlt_l_r  <= pop_desc.dlt_l;
          dlt_r_r  <= pop_desc.dlt_r;
          out_l_r  <= pop_desc.base_l;
          out_r_r  <= pop_desc.base_r;
          last_r   <= 1'b1;
        end
      end
      BK_FRAC: mul_r <= num * RECIP_M;
      BK_MUL: begin
        prod_l_r <= dlt_l_r * frac_s;
        prod_r_r <= dlt_r_r * frac_s;
      end
      BK_RND: begin
        out_l_r <= y_l[15:0];
        out_r_r <= y_r[15:0];
        sum_r   <= sum_c;
        last_r  <= (sum_c > OUT_RATE) || (cnt_r == MAX_OUT - 3'd1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/linear_resampler_to_48k_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_resampler_to_48k_top
// Stereo 16-bit linear-interpolation sample rate converter to 48 kHz.
// ----------------------------------------------------------------------------
// Source words enter on the in_ channel and 48 kHz words leave on the out_
// channel; out_last_of_run marks the final word caused by one source word.
// cfg_source_rate sets the source rate in Hz (reset 48000, which passes words
// through); any write restarts the stream, and writes belong only to idle
// periods. Rates below 8000 step as 8000. A passthrough or first word is
// taken while the back end is idle and offered on out_ in the following
// cycle. Each interpolated word passes in turn through fraction, product,
// rounding and output handshake, the last step waiting while out_ready is
// low, and the back end takes no new source word until a run's last word
// has gone; at 8 kHz a source word makes six words. A source word that makes
// no word while downsampling is consumed without the back end leaving idle.
// The front end and queue take up to QUEUE_DEPTH further source words while
// the back end works.
// ----------------------------------------------------------------------------
module linear_resampler_to_48k_top import lrs_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_left_in,
  input  wire logic signed [15:0] in_right_in,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_left_out,
  output      logic signed [15:0] out_right_out,
  output      logic               out_last_of_run,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [15:0]        cfg_source_rate
);

  logic [15:0] source_rate_r;
  logic [15:0] rate_eff;
  logic        pass_mode;
  logic        cfg_clear;
  logic        push_valid;
  logic        push_ready;
  desc_t       push_desc;
  logic        pop_valid;
  logic        pop_ready;
  desc_t       pop_desc;

  // Configuration register
  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rate_r <= OUT_RATE[15:0];
    end else if (cfg_clear) begin
      source_rate_r <= cfg_source_rate;
    end
  end

  assign pass_mode = (source_rate_r == OUT_RATE[15:0]);
  assign rate_eff  = (source_rate_r < MIN_RATE) ? MIN_RATE : source_rate_r;

  lrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_clear),
    .pass_mode  (pass_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_left_in (in_left_in),
    .in_right_in(in_right_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  lrs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_desc (push_desc),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_desc  (pop_desc)
  );

  lrs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_clear      (cfg_clear),
    .rate_eff       (rate_eff),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_desc       (pop_desc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .out_last_of_run(out_last_of_run)
  );

endmodule
`default_nettype wire

// ----- bench/tb_linear_resampler_to_48k_top.sv -----
// ----------------------------------------------------------------------------
// tb_linear_resampler_to_48k_top
// Self-checking bench for the stereo linear-interpolation resampler to 48 kHz.
// ----------------------------------------------------------------------------
// A queue of source words feeds a bursty driver. A monitor with its own stall
// pattern checks every 48 kHz word against a bit-exact predictor that is
// updated as each source word is taken. Rate settings span passthrough,
// upsampling from 8 kHz (and below), and downsampling up to 65535 Hz.
// ----------------------------------------------------------------------------
module tb_linear_resampler_to_48k_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int PASS_RATE    = 48000;
  localparam int FLOOR_RATE   = 8000;
  localparam int RUN_CAP      = 6;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } src_frame_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } out_frame_t;

  // DUT ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_left_in = '0;
  logic signed [15:0] in_right_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_left_out;
  logic signed [15:0] out_right_out;
  logic               out_last_of_run;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_source_rate = '0;

  // Resampler state mirror
  logic [15:0]        rate_reg = 16'(PASS_RATE);
  logic               have_prev = 1'b0;
  logic signed [15:0] prev_l = '0;
  logic signed [15:0] prev_r = '0;
  int                 next_phase = 0;

  src_frame_t src_q[$];
  out_frame_t out48_q[$];

  int  src_words = 0;
  int  frames_checked = 0;
  int  err_count = 0;
  int  rate_writes = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  mode_cnt = 0;
  int  rx_mode = 0;
  int  hold_cnt = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  logic signed [15:0] gen_l = '0;
  logic signed [15:0] gen_r = '0;

  linear_resampler_to_48k_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_source_rate (cfg_source_rate)
  );

  always #1 clk = ~clk;

  // One channel: Q15 weighted step from prev, rounded half away from zero
  function automatic logic signed [15:0] blend(input int prev, input int delta,
                                                input longint frac);
    longint p;
    p = longint'(delta) * frac;
    p = (p >= 0) ? p + 16384 : p - 16384;
    return 16'(longint'(prev) + p / 32768);
  endfunction

  // Expected 48 kHz words for one accepted source word
  function automatic void resample_frame(input logic signed [15:0] l,
                                         input logic signed [15:0] r);
    int     step;
    int     phase;
    int     dl;
    int     dr;
    int     n;
    longint frac;
    out_frame_t f;
    step = (rate_reg < FLOOR_RATE) ? FLOOR_RATE : int'(rate_reg);
    if (rate_reg == PASS_RATE) begin
      f = '{left: l, right: r, last: 1'b1};
      out48_q.push_back(f);
    end else if (!have_prev) begin
      have_prev = 1'b1;
      prev_l = l;
      prev_r = r;
      next_phase = step & 16'hFFFF;
      f = '{left: l, right: r, last: 1'b1};
      out48_q.push_back(f);
    end else begin
      phase = next_phase;
      dl = int'(l) - int'(prev_l);
      dr = int'(r) - int'(prev_r);
      n = 0;
      while (phase <= PASS_RATE && n < RUN_CAP) begin
        frac = (longint'(phase) * 32768 + 24000) / 48000;
        f.left  = blend(prev_l, dl, frac);
        f.right = blend(prev_r, dr, frac);
        // final word when the next instant falls past this source interval or the run cap is reached
        f.last  = (phase + step > PASS_RATE) || (n == RUN_CAP - 1);
        out48_q.push_back(f);
        n++;
        phase += step;
      end
      next_phase = ((phase > PASS_RATE) ? phase - PASS_RATE : phase) & 16'hFFFF;
      prev_l = l;
      prev_r = r;
    end
  endfunction

  // Source word driver: bursts with random gaps
  always @(posedge clk) begin : src_driver
    src_frame_t nxt;
    if (in_valid && in_ready && rst_n) begin
      resample_frame(in_left_in, in_right_in);
      src_words++;
    end
    if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (src_q.size() != 0) begin
        nxt = src_q.pop_front();
        in_valid    <= 1'b1;
        in_left_in  <= nxt.left;
        in_right_in <= nxt.right;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, switching mode whenever its random mode counter runs out
  always @(posedge clk) begin : rx_pattern
    logic rdy;
    if (mode_cnt == 0) begin
      mode_cnt = $urandom_range(16, 80);
      rx_mode = $urandom_range(0, 3);
    end else begin
      mode_cnt--;
    end
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 1) != 0);
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = ($urandom_range(0, 7) != 0);
    endcase
    out_ready <= rdy && (hold_cnt == 0);
  end

  // One long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin : long_hold
    if (hold_req && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Output word checker
  always @(posedge clk) begin : out_monitor
    out_frame_t want;
    if (out_valid && out_ready && rst_n) begin
      if (out48_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word at cycle %0d: L=%0d R=%0d last=%0b", cycles,
                   out_left_out, out_right_out, out_last_of_run);
      end else begin
        want = out48_q.pop_front();
        frames_checked++;
        if (want.left !== out_left_out || want.right !== out_right_out ||
            want.last !== out_last_of_run) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch at cycle %0d: want L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     cycles, $signed(want.left), $signed(want.right), want.last,
                     out_left_out, out_right_out, out_last_of_run);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void queue_frame(input logic signed [15:0] l,
                                      input logic signed [15:0] r);
    src_frame_t f;
    f = '{left: l, right: r};
    src_q.push_back(f);
  endfunction

  // Random sample: full range, near the last one, or an extreme
  function automatic logic signed [15:0] pick_sample(input logic signed [15:0] last);
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6:    return 16'(int'(last) + int'($urandom_range(0, 1024)) - 512);
      7:          return 16'sd32767;
      8:          return -16'sd32768;
      default:    return ($urandom_range(0, 1) != 0) ? 16'sd0 : -16'sd1;
    endcase
  endfunction

  function automatic void queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      gen_l = pick_sample(gen_l);
      gen_r = pick_sample(gen_r);
      queue_frame(gen_l, gen_r);
    end
  endfunction

  // Wait until every queued word is in and every expected word is out
  task automatic wait_drained();
    while (src_q.size() != 0 || in_valid || out48_q.size() != 0)
      @(posedge clk);
  endtask

  // Idle the block, then write the source rate and restart the mirror
  task automatic write_rate(input logic [15:0] rate);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_source_rate <= rate;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rate_reg = rate;
    have_prev = 1'b0;
    prev_l = '0;
    prev_r = '0;
    next_phase = 0;
    rate_writes++;
  endtask

  initial begin : stimulus
    logic [15:0] rand_rates[12];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: passthrough at reset rate
    queue_frame(16'sd32767, -16'sd32768);
    queue_frame(-16'sd32768, 16'sd32767);
    queue_frame(16'sd0, -16'sd1);
    queue_frame(-16'sd1, 16'sd0);

    // 8 kHz: six words per source word, full-scale deltas both ways
    write_rate(16'd8000);
    queue_frame(16'sd0, 16'sd0);
    queue_frame(16'sd32767, -16'sd32768);
    queue_frame(-16'sd32768, 16'sd32767);
    queue_frame(-16'sd32768, -16'sd32768);
    queue_frame(16'sd32767, 16'sd32767);
    queue_frame(16'sd1, -16'sd1);

    // rate below range steps as 8 kHz
    write_rate(16'd0);
    queue_frame(16'sd100, -16'sd100);
    queue_frame(-16'sd32768, 16'sd32767);
    queue_frame(16'sd32767, -16'sd32768);
    write_rate(16'd7999);
    queue_frame(16'sd5, 16'sd5);
    queue_frame(-16'sd6, 16'sd7);

    // rate above range: some source words make no output
    write_rate(16'd65535);
    queue_frame(16'sd1000, -16'sd1000);
    queue_frame(16'sd32767, -16'sd32768);
    queue_frame(-16'sd32768, 16'sd32767);
    queue_frame(16'sd0, 16'sd0);
    write_rate(16'd48001);
    queue_frame(16'sd123, -16'sd456);
    queue_frame(-16'sd32768, 16'sd32767);
    queue_frame(16'sd32767, -16'sd32768);

    // explicit write of passthrough
    write_rate(16'd48000);
    queue_frame(-16'sd32768, -16'sd32768);
    queue_frame(16'sd32767, 16'sd32767);

    // Random: 8 kHz with the long receiver hold-off
    write_rate(16'd8000);
    queue_random(30);
    hold_req = 1'b1;

    // 44.1 kHz with the sender pausing until all words are out
    write_rate(16'd44100);
    queue_random(8);
    wait_drained();
    queue_random(8);

    rand_rates = '{16'd22050, 16'd11025, 16'd16000, 16'd32000, 16'd47999,
                   16'd50000, 16'd65535, 16'd48000, 16'd24000, 16'd0,
                   16'($urandom), 16'($urandom_range(FLOOR_RATE, PASS_RATE))};
    foreach (rand_rates[i]) begin
      write_rate(rand_rates[i]);
      queue_random($urandom_range(6, 10));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d source words and %0d checked 48 kHz words across %0d rate writes,",
             src_words, frames_checked, rate_writes);
    $display("from below-range upsampling through passthrough to 65535 Hz downsampling.");
    if (err_count == 0 && out48_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- linear_resampler_to_48k_top.f -----
rtl/core/lrs_pkg.sv
rtl/core/lrs_front.sv
rtl/core/lrs_queue.sv
rtl/core/lrs_back.sv
rtl/core/linear_resampler_to_48k_top.sv
bench/tb_linear_resampler_to_48k_top.sv
